### hdl/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the bump allocator with an exact-fit free
// list.
// ----------------------------------------------------------------------------
`default_nettype none

package bae_pkg;

   localparam int unsigned FREE_SLOTS_DEFAULT = 64;
   localparam int unsigned OFFSET_W           = 24;
   localparam int unsigned SIZE_W             = 16;
   localparam int unsigned BUF_W              = 25;
   localparam int unsigned STATUS_W           = 3;

   localparam logic [BUF_W-1:0] BUFFER_BYTES_RESET = BUF_W'(2 * 1024 * 1024);
   localparam logic [BUF_W-1:0] BUFFER_BYTES_CAP   = BUF_W'(16 * 1024 * 1024);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BUMPED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIST_FULL = 3'd4;

   typedef struct packed {
      logic                req_type;
      logic [SIZE_W-1:0]   block_size;
      logic [OFFSET_W-1:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] alloc_offset;
   } rsp_word_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   size;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_MOVE_RD,
      S_MOVE_WR,
      S_BUMP,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

### hdl/bae_ram.sv
// ----------------------------------------------------------------------------
// bae_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hdl/bump_allocator_exact_free_list.sv
// ----------------------------------------------------------------------------
// bump_allocator_exact_free_list
// Allocates blocks from a free list by exact size match, oldest first, or
// else at a bump pointer; frees append to the free list held in one RAM.
// ----------------------------------------------------------------------------
// A free strobes its result in the cycle after it is accepted; an allocate
// walks the listed entries in order, a read and a check for each, then on a
// hit moves the later entries down, and on a miss tries the bump pointer.
// Throughput: one word at a time; busy stays high through the strobe cycle, and
// a new word is accepted in the next cycle. The receiver cannot stall.
// Reset clears the bump pointer and list count and loads the buffer size.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_allocator_exact_free_list #(
   parameter int unsigned FREE_SLOTS = bae_pkg::FREE_SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire bae_pkg::req_word_type    req_word,
   output logic                          rsp_strobe,
   output bae_pkg::rsp_word_type         rsp_word,
   input  wire logic                     csr_wr_en,
   input  wire logic [bae_pkg::BUF_W-1:0] csr_wr_data
);

   import bae_pkg::*;

   localparam int unsigned AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int unsigned CW = $clog2(FREE_SLOTS + 1);
   localparam int unsigned EW = $bits(entry_type);

   state_type             state_ff, state_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [OFFSET_W-1:0]   bump_ff, bump_in;
   logic [BUF_W-1:0]      buffer_ff, buffer_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   rsp_word_type          rsp_ff, rsp_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   entry_type             ram_wdata;
   logic [AW-1:0]         ram_raddr;
   entry_type             ram_rdata;

   logic [CW-1:0]         nxt_idx;
   logic [CW-1:0]         prv_idx;
   logic                  last;
   logic                  hit;
   logic [BUF_W-1:0]      limit;
   logic [BUF_W-1:0]      bump_end;
   logic                  list_full;

   bae_ram #(
      .WIDTH (EW),
      .DEPTH (FREE_SLOTS),
      .AW    (AW)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign nxt_idx   = idx_ff + 1'b1;
   assign prv_idx   = idx_ff - 1'b1;
   assign last      = (nxt_idx >= count_ff);
   assign hit       = (ram_rdata.size == size_ff);
   assign limit     = (buffer_ff > BUFFER_BYTES_CAP) ? BUFFER_BYTES_CAP : buffer_ff;
   assign bump_end  = {1'b0, bump_ff} + {{(BUF_W - SIZE_W){1'b0}}, size_ff};
   assign list_full = ({1'b0, count_ff} >= (CW + 1)'(FREE_SLOTS));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_word.req_type == REQ_FREE) begin
                  state_in = S_RESP;
               end else if (count_ff == '0) begin
                  state_in = S_BUMP;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ:    state_in = S_CHECK;
         S_CHECK: begin
            if (hit) begin
               state_in = last ? S_RESP : S_MOVE_RD;
            end else begin
               state_in = last ? S_BUMP : S_READ;
            end
         end
         S_MOVE_RD: state_in = S_MOVE_WR;
         S_MOVE_WR: state_in = last ? S_RESP : S_MOVE_RD;
         S_BUMP:    state_in = S_RESP;
         S_RESP:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      bump_in   = bump_ff;
      size_in   = size_ff;
      rsp_in    = rsp_ff;
      buffer_in = csr_wr_en ? csr_wr_data : buffer_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in = req_word.block_size;
               idx_in  = '0;
               if (req_word.req_type == REQ_FREE) begin
                  if (list_full) begin
                     rsp_in = '{status: ST_LIST_FULL, alloc_offset: '0};
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     ram_wdata = '{offset: req_word.free_offset,
                                   size:   req_word.block_size};
                     count_in  = count_ff + 1'b1;
                     rsp_in    = '{status: ST_FREED, alloc_offset: '0};
                  end
               end
            end
         end
         S_CHECK: begin
            idx_in = nxt_idx;
            if (hit) begin
               rsp_in = '{status: ST_REUSED, alloc_offset: ram_rdata.offset};
               if (last) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         S_MOVE_WR: begin
            ram_we    = 1'b1;
            ram_waddr = prv_idx[AW-1:0];
            idx_in    = nxt_idx;
            if (last) begin
               count_in = count_ff - 1'b1;
            end
         end
         S_BUMP: begin
            if (bump_end >= limit) begin
               rsp_in = '{status: ST_NO_SPACE, alloc_offset: '0};
            end else begin
               rsp_in  = '{status: ST_BUMPED, alloc_offset: bump_ff};
               bump_in = bump_end[OFFSET_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         count_ff  <= '0;
         bump_ff   <= '0;
         buffer_ff <= BUFFER_BYTES_RESET;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         bump_ff   <= bump_in;
         buffer_ff <= buffer_in;
      end
      size_ff <= size_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);
   assign rsp_word   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= (CW + 1)'(FREE_SLOTS))
      else $error("free list count exceeds capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({{(CW - AW + 1){1'b0}}, ram_waddr} <= {1'b0, count_ff}))
      else $error("free list write beyond its end");

   a_bump_no_space: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == ST_NO_SPACE) |-> $stable(bump_ff))
      else $error("bump pointer moved on out of space");

endmodule

`default_nettype wire

### sim/bump_allocator_exact_free_list_test.sv
// ----------------------------------------------------------------------------
// bump_allocator_exact_free_list_test
// Drives allocate and free words into the allocator under several buffer
// sizes, predicts result words from its own copy of the free list and
// bump pointer or takes them from a table, and compares the strobed words field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_allocator_exact_free_list_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bae_pkg::*;

   localparam int unsigned SLOTS = FREE_SLOTS_DEFAULT;
   localparam int PHASES = 9;
   localparam int RANDOM_PER_PHASE = 215;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type rsp;
   } step_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_word_type        req_word;
   logic                rsp_strobe;
   rsp_word_type        rsp_word;
   logic                csr_wr_en;
   logic [BUF_W-1:0]    csr_wr_data;

   logic [BUF_W-1:0]    buffer_size;
   logic [OFFSET_W-1:0] bump_pointer;
   entry_type           free_list[$];
   entry_type           live_blocks[$];
   rsp_word_type        expected_words[$];
   int                  mismatches = 0;
   int                  idle_cycles = 0;
   int                  burst_left = 0;

   step_row_type directed_steps [20] = '{
      '{'{REQ_ALLOC, 16'h0000, 24'h000000}, 1'b1, '{ST_BUMPED, 24'h000000}},
      '{'{REQ_ALLOC, 16'hFFFF, 24'h000000}, 1'b1, '{ST_BUMPED, 24'h000000}},
      '{'{REQ_ALLOC, 16'h0001, 24'h000000}, 1'b1, '{ST_BUMPED, 24'h00FFFF}},
      '{'{REQ_FREE,  16'hFFFF, 24'hFFFFFF}, 1'b1, '{ST_FREED, 24'h000000}},
      '{'{REQ_FREE,  16'h0000, 24'h000000}, 1'b1, '{ST_FREED, 24'h000000}},
      '{'{REQ_FREE,  16'h5A5A, 24'h123456}, 1'b1, '{ST_FREED, 24'h000000}},
      '{'{REQ_ALLOC, 16'h0000, 24'h000000}, 1'b1, '{ST_REUSED, 24'h000000}},
      '{'{REQ_ALLOC, 16'hFFFF, 24'h000000}, 1'b1, '{ST_REUSED, 24'hFFFFFF}},
      '{'{REQ_ALLOC, 16'h5A5A, 24'h000000}, 1'b1, '{ST_REUSED, 24'h123456}},
      '{'{REQ_ALLOC, 16'h5A5A, 24'h000000}, 1'b0, '0},
      '{'{REQ_FREE,  16'hA5A5, 24'hA5A5A5}, 1'b0, '0},
      '{'{REQ_FREE,  16'h0010, 24'h000100}, 1'b0, '0},
      '{'{REQ_FREE,  16'h0020, 24'h000200}, 1'b0, '0},
      '{'{REQ_FREE,  16'h0010, 24'h000300}, 1'b0, '0},
      '{'{REQ_ALLOC, 16'h0010, 24'h000000}, 1'b0, '0},
      '{'{REQ_ALLOC, 16'h0010, 24'h000000}, 1'b0, '0},
      '{'{REQ_ALLOC, 16'h0020, 24'h000000}, 1'b0, '0},
      '{'{REQ_ALLOC, 16'hA5A5, 24'hFFFFFF}, 1'b0, '0},
      '{'{REQ_ALLOC, 16'h0000, 24'h000000}, 1'b0, '0},
      '{'{REQ_FREE,  16'h8000, 24'h800000}, 1'b0, '0}
   };

   bump_allocator_exact_free_list dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic rsp_word_type predict_word(input req_word_type word);
      rsp_word_type result;
      entry_type    fresh;
      int unsigned  limit;
      int unsigned  end_addr;
      result = '0;
      if (word.req_type == REQ_FREE) begin
         if (free_list.size() >= SLOTS) begin
            result.status = ST_LIST_FULL;
         end else begin
            fresh.offset = word.free_offset;
            fresh.size = word.block_size;
            free_list.push_back(fresh);
            result.status = ST_FREED;
         end
         return result;
      end
      foreach (free_list[i]) begin
         if (free_list[i].size == word.block_size) begin
            result.status = ST_REUSED;
            result.alloc_offset = free_list[i].offset;
            free_list.delete(i);
            return result;
         end
      end
      limit = (buffer_size > BUFFER_BYTES_CAP) ? BUFFER_BYTES_CAP : buffer_size;
      end_addr = bump_pointer + word.block_size;
      if (end_addr >= limit) begin
         result.status = ST_NO_SPACE;
      end else begin
         result.status = ST_BUMPED;
         result.alloc_offset = bump_pointer;
         bump_pointer = end_addr[OFFSET_W-1:0];
      end
      return result;
   endfunction

   // Most frees return a live block and, while the free list holds entries, half
   // the allocates ask for a size waiting on it, so reuse and list-full paths are reached.
   function automatic req_word_type make_word(input int free_pct);
      req_word_type word;
      int           idx;
      int           pick;
      word.req_type = ($urandom_range(99) < free_pct) ? REQ_FREE : REQ_ALLOC;
      word.block_size = 16'($urandom);
      word.free_offset = 24'($urandom);
      pick = $urandom_range(9);
      if (word.req_type == REQ_FREE) begin
         if (live_blocks.size() > 0 && pick < 8) begin
            idx = $urandom_range(live_blocks.size() - 1);
            word.free_offset = live_blocks[idx].offset;
            word.block_size = live_blocks[idx].size;
            live_blocks.delete(idx);
         end
      end else if (free_list.size() > 0 && pick < 5) begin
         word.block_size = free_list[$urandom_range(free_list.size() - 1)].size;
      end else if (pick < 8) begin
         if ($urandom_range(3) == 0)
            word.block_size = 16'hFFFF;
         else
            word.block_size = 16'(1 << $urandom_range(15)) - 16'($urandom_range(1));
      end
      return word;
   endfunction

   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(19) == 0) begin
         burst_left = $urandom_range(40, 8);
         return 0;
      end
      return $urandom_range(18);
   endfunction

   function automatic logic [BUF_W-1:0] phase_buffer_size(input int phase);
      case (phase)
         1: begin
            return '0;
         end
         2: begin
            return BUF_W'(1);
         end
         3: begin
            return BUF_W'(4096);
         end
         5: begin
            return '1;
         end
         6: begin
            return BUF_W'(1000);
         end
         7: begin
            return BUFFER_BYTES_RESET;
         end
         default: begin
            return BUFFER_BYTES_CAP;
         end
      endcase
   endfunction

   task automatic send_word(input req_word_type word, input logic typed,
                            input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type predicted;
      entry_type    block;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= word;
      do @(posedge clock); while (busy);
      predicted = predict_word(word);
      expected_words.push_back(typed ? typed_rsp : predicted);
      if (predicted.status == ST_REUSED || predicted.status == ST_BUMPED) begin
         block.offset = predicted.alloc_offset;
         block.size = word.block_size;
         live_blocks.push_back(block);
         if (live_blocks.size() > 256) void'(live_blocks.pop_front());
      end
   endtask

   task automatic write_buffer_size(input logic [BUF_W-1:0] value);
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      buffer_size = value;
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (rsp_strobe && !reset) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word, status %0d offset %h",
                                      rsp_word.status, rsp_word.alloc_offset));
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_word.status, want.status));
            if (rsp_word.alloc_offset !== want.alloc_offset)
               report_mismatch($sformatf("alloc_offset %h, expected %h",
                                         rsp_word.alloc_offset, want.alloc_offset));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int phase;
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      buffer_size = BUFFER_BYTES_RESET;
      bump_pointer = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_steps[i])
         send_word(directed_steps[i].word, directed_steps[i].typed, directed_steps[i].rsp);
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) write_buffer_size(phase_buffer_size(phase));
         repeat (RANDOM_PER_PHASE)
            send_word(make_word((phase % 2 == 0) ? 75 : 30), 1'b0, '0);
      end
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
